>>> src/nllf_pkg.sv
// ----------------------------------------------------------------------------
// nllf_pkg
// shared constants, codes and controller/datapath command types for the
// normalized lattice-ladder filter
// ----------------------------------------------------------------------------
package nllf_pkg;

    // build-time sizes
    localparam int MAX_ORDER    = 16;
    localparam int SAMPLE_WIDTH = 16;
    localparam int BACK_W       = SAMPLE_WIDTH + 8;

    // fixed field widths
    localparam int REQ_W       = 2;
    localparam int IDX_W       = 5;
    localparam int COEF_W      = 16;
    localparam int COMP_W      = 15;
    localparam int LADDER_W    = 16;
    localparam int ORDER_REG_W = 5;
    localparam int GAIN_W      = 32;

    // fraction bits of the coefficient formats
    localparam int COEF_FRAC   = 15;
    localparam int LADDER_FRAC = 12;
    localparam int GAIN_FRAC   = 16;

    // store addressing
    localparam int STAGE_AW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
    localparam int TAP_AW   = $clog2(MAX_ORDER + 1);

    // input tdata layout, lowest field first
    localparam int SAMPLE_LSB  = 0;
    localparam int INDEX_LSB   = SAMPLE_LSB + SAMPLE_WIDTH;
    localparam int REFL_LSB    = INDEX_LSB + IDX_W;
    localparam int COMP_LSB    = REFL_LSB + COEF_W;
    localparam int LADDER_LSB  = COMP_LSB + COMP_W;
    localparam int IN_FIELDS_W = LADDER_LSB + LADDER_W;
    localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8;

    // request kinds
    typedef logic [REQ_W-1:0] t_req;
    localparam t_req REQ_FILTER     = 2'd0;
    localparam t_req REQ_LOAD_STAGE = 2'd1;
    localparam t_req REQ_LOAD_TAP   = 2'd2;

    // configuration registers
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_ORDER = 1'b0;
    localparam t_cfg_idx CFG_GAIN  = 1'b1;

    localparam logic [ORDER_REG_W-1:0]  ORDER_RESET = 5'd1;
    localparam logic signed [GAIN_W-1:0] GAIN_RESET = 32'sd65536;

    // controller to datapath
    typedef struct packed {
        logic                start;       // latch sample, clear ladder sum
        logic                load_stage;  // write k and c from the input item
        logic                load_tap;    // write nu from the input item
        logic                rd_en;       // fetch store entries
        logic [STAGE_AW-1:0] rd_stage;
        logic [TAP_AW-1:0]   rd_tap;
        logic                mul_old;     // products with the old backward value
        logic                mul_f;       // products with the forward value
        logic                stage_end;   // combine, write b[j+1], feed ladder
        logic [TAP_AW-1:0]   wr_tap;
        logic                tail;        // write b[0], feed last ladder term
        logic                rnd_en;      // round and clip ladder sum
        logic                gain_en;     // gain multiply
        logic                out_load;    // load the output register
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_free;
    } t_dp_stat;

endpackage

>>> src/nllf_ctrl.sv
// ----------------------------------------------------------------------------
// nllf_ctrl
// sequencer: takes items, walks the lattice stages from the top down and
// steps the ladder, gain and output phases
// ----------------------------------------------------------------------------
module nllf_ctrl
    import nllf_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  t_req                   i_req_type,
    input  logic [IDX_W-1:0]       i_coef_index,
    input  logic [ORDER_REG_W-1:0] i_order,
    input  t_dp_stat               i_stat,
    output t_dp_cmd                o_cmd
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_READ = 4'd1;
    localparam logic [3:0] S_P0   = 4'd2;
    localparam logic [3:0] S_P1   = 4'd3;
    localparam logic [3:0] S_P2   = 4'd4;
    localparam logic [3:0] S_TAIL = 4'd5;
    localparam logic [3:0] S_D1   = 4'd6;
    localparam logic [3:0] S_D2   = 4'd7;
    localparam logic [3:0] S_RND  = 4'd8;
    localparam logic [3:0] S_GAIN = 4'd9;
    localparam logic [3:0] S_OUT  = 4'd10;

    logic [3:0]          r_state, n_state;
    logic [TAP_AW-1:0]   r_n, n_n;
    logic [STAGE_AW-1:0] r_j, n_j;
    logic [TAP_AW-1:0]   order_clamped;
    logic                accept;

    assign order_clamped = (int'(i_order) > MAX_ORDER) ? TAP_AW'(MAX_ORDER)
                                                       : TAP_AW'(i_order);
    assign o_ready = (r_state == S_IDLE);
    assign accept  = i_valid && o_ready;

    always_comb begin
        n_state = r_state;
        n_n     = r_n;
        n_j     = r_j;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (i_req_type)
                        REQ_FILTER: begin
                            o_cmd.start = 1'b1;
                            n_n         = order_clamped;
                            n_j         = STAGE_AW'(order_clamped - TAP_AW'(1));
                            n_state     = S_READ;
                        end
                        REQ_LOAD_STAGE: begin
                            o_cmd.load_stage = (int'(i_coef_index) < MAX_ORDER);
                        end
                        REQ_LOAD_TAP: begin
                            o_cmd.load_tap = (int'(i_coef_index) <= MAX_ORDER);
                        end
                        default: ;
                    endcase
                end
            end
            S_READ: begin
                // top stage operands and tap nu[n]
                o_cmd.rd_en    = 1'b1;
                o_cmd.rd_stage = r_j;
                o_cmd.rd_tap   = r_n;
                n_state        = (r_n == '0) ? S_TAIL : S_P0;
            end
            S_P0: begin
                o_cmd.mul_old = 1'b1;
                n_state       = S_P1;
            end
            S_P1: begin
                o_cmd.mul_f = 1'b1;
                n_state     = S_P2;
            end
            S_P2: begin
                o_cmd.stage_end = 1'b1;
                o_cmd.wr_tap    = TAP_AW'(r_j) + TAP_AW'(1);
                o_cmd.rd_en     = 1'b1;
                o_cmd.rd_stage  = r_j - STAGE_AW'(1);
                o_cmd.rd_tap    = TAP_AW'(r_j);
                if (r_j == '0) begin
                    n_state = S_TAIL;
                end else begin
                    n_j     = r_j - STAGE_AW'(1);
                    n_state = S_P0;
                end
            end
            S_TAIL: begin
                o_cmd.tail = 1'b1;
                n_state    = S_D1;
            end
            S_D1:   n_state = S_D2;
            S_D2:   n_state = S_RND;
            S_RND: begin
                o_cmd.rnd_en = 1'b1;
                n_state      = S_GAIN;
            end
            S_GAIN: begin
                o_cmd.gain_en = 1'b1;
                n_state       = S_OUT;
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_n     <= '0;
            r_j     <= '0;
        end else begin
            r_state <= n_state;
            r_n     <= n_n;
            r_j     <= n_j;
        end
    end

endmodule

>>> src/nllf_datapath.sv
// ----------------------------------------------------------------------------
// nllf_datapath
// coefficient and backward stores, shared lattice multiplier pair, ladder
// multiply-accumulate, gain stage and output register
// ----------------------------------------------------------------------------
module nllf_datapath
    import nllf_pkg::*;
(
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  t_dp_cmd                        i_cmd,
    output t_dp_stat                       o_stat,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample,
    input  logic [IDX_W-1:0]               i_coef_index,
    input  logic signed [COEF_W-1:0]       i_refl,
    input  logic [COMP_W-1:0]              i_comp,
    input  logic signed [LADDER_W-1:0]     i_ladder,
    input  logic signed [GAIN_W-1:0]       i_gain,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic signed [SAMPLE_WIDTH-1:0] o_out_sample,
    output logic                           o_out_sat
);

    localparam int PROD_W   = BACK_W + COEF_W;
    localparam int SUM_W    = PROD_W + 2;
    localparam int LAT_SH_W = SUM_W - COEF_FRAC;
    localparam int LPROD_W  = BACK_W + LADDER_W;
    localparam int ACC_W    = LPROD_W + TAP_AW;
    localparam int LAD_SH_W = ACC_W + 1 - LADDER_FRAC;
    localparam int GPROD_W  = 2 * GAIN_W;
    localparam int G_SH_W   = GPROD_W + 1 - GAIN_FRAC;

    localparam logic signed [SUM_W-1:0] LAT_HALF =
        {{(SUM_W - COEF_FRAC){1'b0}}, 1'b1, {(COEF_FRAC - 1){1'b0}}};
    localparam logic signed [ACC_W:0] LAD_HALF =
        {{(ACC_W + 1 - LADDER_FRAC){1'b0}}, 1'b1, {(LADDER_FRAC - 1){1'b0}}};
    localparam logic signed [GPROD_W:0] G_HALF =
        {{(GPROD_W + 1 - GAIN_FRAC){1'b0}}, 1'b1, {(GAIN_FRAC - 1){1'b0}}};

    localparam logic signed [BACK_W-1:0] BACK_MAX = {1'b0, {(BACK_W - 1){1'b1}}};
    localparam logic signed [BACK_W-1:0] BACK_MIN = {1'b1, {(BACK_W - 1){1'b0}}};
    localparam logic signed [GAIN_W-1:0] LAD_MAX  = {1'b0, {(GAIN_W - 1){1'b1}}};
    localparam logic signed [GAIN_W-1:0] LAD_MIN  = {1'b1, {(GAIN_W - 1){1'b0}}};
    localparam logic signed [SAMPLE_WIDTH-1:0] OUT_MAX =
        {1'b0, {(SAMPLE_WIDTH - 1){1'b1}}};
    localparam logic signed [SAMPLE_WIDTH-1:0] OUT_MIN =
        {1'b1, {(SAMPLE_WIDTH - 1){1'b0}}};

    // stores
    logic signed [COEF_W-1:0]   r_refl_mem [0:MAX_ORDER-1];
    logic [COMP_W-1:0]          r_comp_mem [0:MAX_ORDER-1];
    logic signed [LADDER_W-1:0] r_tap_mem  [0:MAX_ORDER];
    logic signed [BACK_W-1:0]   r_back_mem [0:MAX_ORDER];
    logic [MAX_ORDER:0]         r_back_valid;

    // registered store reads
    logic signed [COEF_W-1:0]   r_k_rd;
    logic [COMP_W-1:0]          r_c_rd;
    logic signed [LADDER_W-1:0] r_nu_rd;
    logic signed [BACK_W-1:0]   r_b_rd;

    // lattice
    logic signed [BACK_W-1:0] r_f;
    logic signed [BACK_W-1:0] mul_a;
    logic signed [COEF_W-1:0] comp_s, m0_b, m1_b;
    logic signed [PROD_W-1:0] m0, m1;
    logic signed [PROD_W-1:0] r_p_oc, r_p_ko, r_p_kf, r_p_fc;
    logic signed [SUM_W-1:0]  b_sum, f_sum;
    logic signed [LAT_SH_W-1:0] b_sh, f_sh;
    logic [LAT_SH_W-BACK_W:0] b_hi, f_hi;
    logic                     b_ovf, f_ovf;
    logic signed [BACK_W-1:0] b_new, f_new;
    logic                     back_we;
    logic [TAP_AW-1:0]        back_wa;
    logic signed [BACK_W-1:0] back_wd;

    // ladder
    logic                       r_lad_v, r_lp_v;
    logic signed [BACK_W-1:0]   r_lad_b;
    logic signed [LADDER_W-1:0] r_lad_nu;
    logic signed [LPROD_W-1:0]  lad_prod, r_lp;
    logic signed [ACC_W-1:0]    r_acc;
    logic signed [ACC_W:0]      lad_sum;
    logic signed [LAD_SH_W-1:0] lad_sh;
    logic [LAD_SH_W-GAIN_W:0]   lad_hi;
    logic signed [GAIN_W-1:0]   lad_sat, r_ladder;

    // gain and output
    logic signed [GPROD_W-1:0]       r_gprod;
    logic signed [GPROD_W:0]         g_sum;
    logic signed [G_SH_W-1:0]        g_sh;
    logic [G_SH_W-SAMPLE_WIDTH:0]    g_hi;
    logic                            g_ovf;
    logic signed [SAMPLE_WIDTH-1:0]  g_sat;
    logic                            r_out_valid;
    logic signed [SAMPLE_WIDTH-1:0]  r_out_sample;
    logic                            r_out_sat;

    // ---- coefficient stores
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_stage) begin
            r_refl_mem[STAGE_AW'(i_coef_index)] <= i_refl;
            r_comp_mem[STAGE_AW'(i_coef_index)] <= i_comp;
        end
        if (i_cmd.load_tap) begin
            r_tap_mem[TAP_AW'(i_coef_index)] <= i_ladder;
        end
        if (i_cmd.rd_en) begin
            r_k_rd  <= r_refl_mem[i_cmd.rd_stage];
            r_c_rd  <= r_comp_mem[i_cmd.rd_stage];
            r_nu_rd <= r_tap_mem[i_cmd.rd_tap];
            r_b_rd  <= r_back_valid[TAP_AW'(i_cmd.rd_stage)]
                       ? r_back_mem[TAP_AW'(i_cmd.rd_stage)] : '0;
        end
    end

    // ---- backward store, zero until written
    assign back_we = i_cmd.stage_end || i_cmd.tail;
    assign back_wa = i_cmd.tail ? '0 : i_cmd.wr_tap;
    assign back_wd = i_cmd.tail ? r_f : b_new;

    always_ff @(posedge i_clk) begin
        if (back_we) begin
            r_back_mem[back_wa] <= back_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_back_valid <= '0;
        end else if (back_we) begin
            r_back_valid[back_wa] <= 1'b1;
        end
    end

    // ---- lattice multiplier pair: old*c and k*old, then k*f and f*c
    assign comp_s = $signed({1'b0, r_c_rd});
    assign mul_a  = i_cmd.mul_old ? r_b_rd : r_f;
    assign m0_b   = i_cmd.mul_old ? comp_s : r_k_rd;
    assign m1_b   = i_cmd.mul_old ? r_k_rd : comp_s;
    assign m0     = mul_a * m0_b;
    assign m1     = mul_a * m1_b;

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_old) begin
            r_p_oc <= m0;
            r_p_ko <= m1;
        end
        if (i_cmd.mul_f) begin
            r_p_kf <= m0;
            r_p_fc <= m1;
        end
    end

    // round half up, then clip to the backward width
    assign b_sum = SUM_W'(r_p_oc) + SUM_W'(r_p_kf) + LAT_HALF;
    assign f_sum = SUM_W'(r_p_fc) - SUM_W'(r_p_ko) + LAT_HALF;
    assign b_sh  = b_sum[SUM_W-1:COEF_FRAC];
    assign f_sh  = f_sum[SUM_W-1:COEF_FRAC];
    assign b_hi  = b_sh[LAT_SH_W-1:BACK_W-1];
    assign f_hi  = f_sh[LAT_SH_W-1:BACK_W-1];
    assign b_ovf = !((&b_hi) || !(|b_hi));
    assign f_ovf = !((&f_hi) || !(|f_hi));
    assign b_new = b_ovf ? (b_sh[LAT_SH_W-1] ? BACK_MIN : BACK_MAX) : b_sh[BACK_W-1:0];
    assign f_new = f_ovf ? (f_sh[LAT_SH_W-1] ? BACK_MIN : BACK_MAX) : f_sh[BACK_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_f <= BACK_W'(i_sample);
        end else if (i_cmd.stage_end) begin
            r_f <= f_new;
        end
    end

    // ---- ladder multiply-accumulate, fed as each backward value settles
    assign lad_prod = r_lad_b * r_lad_nu;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lad_v <= 1'b0;
            r_lp_v  <= 1'b0;
        end else begin
            r_lad_v <= i_cmd.stage_end || i_cmd.tail;
            r_lp_v  <= r_lad_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.stage_end) begin
            r_lad_b  <= b_new;
            r_lad_nu <= r_nu_rd;
        end else if (i_cmd.tail) begin
            r_lad_b  <= r_f;
            r_lad_nu <= r_nu_rd;
        end
        r_lp <= lad_prod;
        if (i_cmd.start) begin
            r_acc <= '0;
        end else if (r_lp_v) begin
            r_acc <= r_acc + ACC_W'(r_lp);
        end
    end

    assign lad_sum = (ACC_W + 1)'(r_acc) + LAD_HALF;
    assign lad_sh  = lad_sum[ACC_W:LADDER_FRAC];
    assign lad_hi  = lad_sh[LAD_SH_W-1:GAIN_W-1];
    assign lad_sat = ((&lad_hi) || !(|lad_hi)) ? lad_sh[GAIN_W-1:0]
                   : (lad_sh[LAD_SH_W-1] ? LAD_MIN : LAD_MAX);

    // ---- gain and output clip
    always_ff @(posedge i_clk) begin
        if (i_cmd.rnd_en) begin
            r_ladder <= lad_sat;
        end
        if (i_cmd.gain_en) begin
            r_gprod <= r_ladder * i_gain;
        end
    end

    assign g_sum = (GPROD_W + 1)'(r_gprod) + G_HALF;
    assign g_sh  = g_sum[GPROD_W:GAIN_FRAC];
    assign g_hi  = g_sh[G_SH_W-1:SAMPLE_WIDTH-1];
    assign g_ovf = !((&g_hi) || !(|g_hi));
    assign g_sat = g_ovf ? (g_sh[G_SH_W-1] ? OUT_MIN : OUT_MAX)
                         : g_sh[SAMPLE_WIDTH-1:0];

    // ---- output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_sample <= g_sat;
            r_out_sat    <= g_ovf;
        end
    end

    assign o_stat.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_out_sample    = r_out_sample;
    assign o_out_sat       = r_out_sat;

endmodule

>>> src/normalized_lattice_ladder_filter_unit.sv
// ----------------------------------------------------------------------------
// normalized_lattice_ladder_filter_unit
// normalized lattice-ladder iir filter, fixed point, with coefficient load
// items and a streaming sample path
// ----------------------------------------------------------------------------
// Items arrive on the s_axis side; tuser says what an item is: a sample to
// filter, a lattice stage load (k in Q1.15 and c = sqrt(1-k^2) in unsigned
// Q0.15) or a ladder tap load (nu, Q4.12). Loads give no result and leave
// the unit ready; a stage load at index MAX_ORDER or above, a tap load above
// MAX_ORDER and an unknown kind are dropped. A sample item gives one result
// on the m_axis side: the lattice is walked from stage order-1 down to stage
// 0 on one shared pair of multipliers, each stage forming the products with
// the old backward value, then those with the forward value, then combining
// them, while a separate multiply-accumulate builds the ladder sum as each
// backward value settles; the sum is rounded, clipped to 32 bits, scaled by
// output_gain (Q16.16) and rounded and clipped to the sample width, with
// tuser flagging a clip. A sample's result becomes valid in the same cycle
// as the unit is ready again. A finished result waits in the output
// register and the next item is taken meanwhile; only a second result
// stalls until the first is taken.
// The backward store reads as zero after reset; coefficients must be
// loaded before a sample uses them. Orders above MAX_ORDER act as
// MAX_ORDER, an order of zero passes the sample through the ladder alone.
// Configuration: write filter_order (index 0) and output_gain (index 1)
// only while the block is idle.
// ----------------------------------------------------------------------------
module normalized_lattice_ladder_filter_unit
    import nllf_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,

    // configuration write port
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]  i_cfg_wdata,

    // item input
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // sample_in, coef_index, refl_coef, comp_coef, ladder_coef, zero pad
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // req_type
    input  logic [REQ_W-1:0]       s_axis_tuser,

    // result output
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // sample_out, zero pad
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // saturated
    output logic [0:0]             m_axis_tuser
);

    // configuration registers
    logic [ORDER_REG_W-1:0]   r_order;
    logic signed [GAIN_W-1:0] r_gain;

    // unpacked item fields
    logic signed [SAMPLE_WIDTH-1:0] in_sample;
    logic [IDX_W-1:0]               in_index;
    logic signed [COEF_W-1:0]       in_refl;
    logic [COMP_W-1:0]              in_comp;
    logic signed [LADDER_W-1:0]     in_ladder;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;
    logic [SAMPLE_WIDTH-1:0] out_sample;
    logic                    out_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order <= ORDER_RESET;
            r_gain  <= GAIN_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_ORDER) begin
                r_order <= i_cfg_wdata[ORDER_REG_W-1:0];
            end else if (i_cfg_idx == CFG_GAIN) begin
                r_gain  <= i_cfg_wdata[GAIN_W-1:0];
            end
        end
    end

    assign in_sample = s_axis_tdata[SAMPLE_LSB +: SAMPLE_WIDTH];
    assign in_index  = s_axis_tdata[INDEX_LSB  +: IDX_W];
    assign in_refl   = s_axis_tdata[REFL_LSB   +: COEF_W];
    assign in_comp   = s_axis_tdata[COMP_LSB   +: COMP_W];
    assign in_ladder = s_axis_tdata[LADDER_LSB +: LADDER_W];

    // sequencer
    nllf_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_req_type   (s_axis_tuser),
        .i_coef_index (in_index),
        .i_order      (r_order),
        .i_stat       (dp_stat),
        .o_cmd        (dp_cmd)
    );

    // stores, arithmetic and output register
    nllf_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (dp_cmd),
        .o_stat       (dp_stat),
        .i_sample     (in_sample),
        .i_coef_index (in_index),
        .i_refl       (in_refl),
        .i_comp       (in_comp),
        .i_ladder     (in_ladder),
        .i_gain       (r_gain),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .o_out_sample (out_sample),
        .o_out_sat    (out_sat)
    );

    assign m_axis_tdata    = OUT_TDATA_W'(out_sample);
    assign m_axis_tuser[0] = out_sat;

endmodule

>>> src/nllf_checker.sv
// ----------------------------------------------------------------------------
// nllf_checker
// port-level checks on the filter unit's handshakes and result flags
// ----------------------------------------------------------------------------
module nllf_checker
    import nllf_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic [REQ_W-1:0]       s_axis_tuser,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input logic [0:0]             m_axis_tuser
);

    localparam logic [SAMPLE_WIDTH-1:0] OUT_MAX = {1'b0, {(SAMPLE_WIDTH - 1){1'b1}}};
    localparam logic [SAMPLE_WIDTH-1:0] OUT_MIN = {1'b1, {(SAMPLE_WIDTH - 1){1'b0}}};

    // a waiting result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // and keeps its value
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // a sample item leaves the unit not ready while it works on it
    a_filter_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == REQ_FILTER)
        |=> !s_axis_tready ##1 !s_axis_tready)
        else $error("unit ready too soon after a sample item");

    // loads and unknown items leave the unit ready
    a_load_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser != REQ_FILTER) |=> s_axis_tready)
        else $error("unit left ready after a non-sample item");

    // a clip flag goes with a full-scale value
    a_sat_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0]
        |-> (m_axis_tdata[SAMPLE_WIDTH-1:0] == OUT_MAX)
         || (m_axis_tdata[SAMPLE_WIDTH-1:0] == OUT_MIN))
        else $error("clip flag on a value that is not full scale");

endmodule

bind normalized_lattice_ladder_filter_unit nllf_checker u_nllf_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

>>> dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench for normalized_lattice_ladder_filter_unit
// loads lattice stages and ladder taps, streams samples through several
// order and gain settings with random idling on both sides, and checks each
// filtered sample against a bit-exact fixed-point lattice-ladder predictor
// ----------------------------------------------------------------------------
module testbench;
    import nllf_pkg::*;

    // the package names no code for the fourth request kind; the block drops it
    localparam t_req REQ_UNKNOWN = 2'd3;

    // cycles without any handshake before the run is declared hung
    localparam int STALL_LIMIT = 2000;
    // worst sample latency at full order plus margin, used before config writes
    localparam int SETTLE_CYCLES = 3 * MAX_ORDER + 12;

    typedef struct packed {
        logic [SAMPLE_WIDTH-1:0] value;
        logic                    clipped;
    } t_filtered;

    // ------------------------------------------------------------------------
    // scoreboard: own copy of coefficients, backward store and registers,
    // plus the queue of filtered samples still owed by the block
    // ------------------------------------------------------------------------
    class lattice_checker;
        int unsigned order_reg;
        longint      gain;
        longint      refl_k   [MAX_ORDER];
        longint      comp_c   [MAX_ORDER];
        longint      ladder_nu[MAX_ORDER+1];
        longint      back     [MAX_ORDER+1];
        t_filtered   filtered_pending[$];
        int          errors;

        function new();
            order_reg = ORDER_RESET;
            gain      = GAIN_RESET;
            foreach (refl_k[i]) refl_k[i] = 0;
            foreach (comp_c[i]) comp_c[i] = 0;
            foreach (ladder_nu[i]) ladder_nu[i] = 0;
            foreach (back[i]) back[i] = 0;
            errors = 0;
        endfunction

        // floor((v + 2^(s-1)) / 2^s)
        function longint round_shift(longint v, int s);
            return (v + (64'sd1 <<< (s - 1))) >>> s;
        endfunction

        function longint clip_to(longint v, int w);
            longint hi;
            longint lo;
            hi = (64'sd1 <<< (w - 1)) - 1;
            lo = -hi - 1;
            if (v > hi) return hi;
            if (v < lo) return lo;
            return v;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] v);
            if (idx == CFG_ORDER)
                order_reg = v[ORDER_REG_W-1:0];
            else
                gain = longint'($signed(v[GAIN_W-1:0]));
        endfunction

        function t_filtered filter_sample(longint x);
            t_filtered r;
            longint    f;
            longint    old;
            longint    acc;
            longint    scaled;
            int        n;
            int        i;
            n = (order_reg > MAX_ORDER) ? MAX_ORDER : int'(order_reg);
            f = x;
            // walk stages from the top down, each with the old lower backward value
            for (i = n; i >= 1; i--) begin
                old = back[i-1];
                back[i] = clip_to(round_shift(old * comp_c[i-1] + refl_k[i-1] * f,
                                              COEF_FRAC), BACK_W);
                f = clip_to(round_shift(f * comp_c[i-1] - refl_k[i-1] * old,
                                        COEF_FRAC), BACK_W);
            end
            back[0] = f;
            acc = 0;
            for (i = 0; i <= n; i++)
                acc += back[i] * ladder_nu[i];
            acc    = clip_to(round_shift(acc, LADDER_FRAC), 32);
            scaled = round_shift(acc * gain, GAIN_FRAC);
            acc    = clip_to(scaled, SAMPLE_WIDTH);
            r.value   = acc[SAMPLE_WIDTH-1:0];
            r.clipped = (acc != scaled);
            return r;
        endfunction

        function void note_item(t_req req, logic [IN_TDATA_W-1:0] d);
            logic [IDX_W-1:0] idx;
            idx = d[INDEX_LSB +: IDX_W];
            case (req)
                REQ_LOAD_STAGE: begin
                    if (idx < MAX_ORDER) begin
                        refl_k[idx] = longint'($signed(d[REFL_LSB +: COEF_W]));
                        comp_c[idx] = longint'(d[COMP_LSB +: COMP_W]);
                    end
                end
                REQ_LOAD_TAP: begin
                    if (idx <= MAX_ORDER)
                        ladder_nu[idx] = longint'($signed(d[LADDER_LSB +: LADDER_W]));
                end
                REQ_FILTER: begin
                    filtered_pending.push_back(
                        filter_sample(longint'($signed(d[SAMPLE_LSB +: SAMPLE_WIDTH]))));
                end
                default: ;
            endcase
        endfunction

        function void check_result(logic [OUT_TDATA_W-1:0] d, logic sat_flag);
            t_filtered want;
            if (filtered_pending.size() == 0) begin
                $display("%0t: unexpected result sample_out %0d saturated %0b",
                         $time, $signed(d[SAMPLE_WIDTH-1:0]), sat_flag);
                errors++;
                return;
            end
            want = filtered_pending.pop_front();
            if (d[SAMPLE_WIDTH-1:0] !== want.value) begin
                $display("%0t: sample_out expected %0d actual %0d", $time,
                         $signed(want.value), $signed(d[SAMPLE_WIDTH-1:0]));
                errors++;
            end
            if (sat_flag !== want.clipped) begin
                $display("%0t: saturated expected %0b actual %0b", $time,
                         want.clipped, sat_flag);
                errors++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // block under test
    // ------------------------------------------------------------------------
    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    t_cfg_idx               i_cfg_idx;
    logic [CFG_DATA_W-1:0]  i_cfg_wdata;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    // sample_in, coef_index, refl_coef, comp_coef, ladder_coef, zero pad
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    // req_type
    t_req                   s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    // sample_out, zero pad
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    // saturated
    logic [0:0]             m_axis_tuser;

    normalized_lattice_ladder_filter_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    lattice_checker sb;
    // set for the closing phase: no idling on either side
    bit calm = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // item packing and stage coefficient helpers
    // ------------------------------------------------------------------------
    function automatic logic [IN_TDATA_W-1:0] pack_item(
        logic [SAMPLE_WIDTH-1:0] s, logic [IDX_W-1:0] idx, logic [COEF_W-1:0] k,
        logic [COMP_W-1:0] c, logic [LADDER_W-1:0] nu);
        logic [IN_TDATA_W-1:0] d;
        d = '0;
        d[SAMPLE_LSB +: SAMPLE_WIDTH] = s;
        d[INDEX_LSB  +: IDX_W]        = idx;
        d[REFL_LSB   +: COEF_W]       = k;
        d[COMP_LSB   +: COMP_W]       = c;
        d[LADDER_LSB +: LADDER_W]     = nu;
        return d;
    endfunction

    // c = sqrt(1 - k^2) in unsigned Q0.15, as a stage load expects
    function automatic int stage_comp(int k);
        real r;
        int  c;
        r = $sqrt(1073741824.0 - real'(k) * real'(k));
        c = $rtoi(r + 0.5);
        if (c > 32767) c = 32767;
        return c;
    endfunction

    // ------------------------------------------------------------------------
    // input side: one item per call, optional random gap before it;
    // returns right after the accepting edge with tvalid still high
    // ------------------------------------------------------------------------
    task automatic send_item(t_req req, logic [IN_TDATA_W-1:0] d);
        @(negedge i_clk);
        if (!calm && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        s_axis_tuser  <= req;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic send_sample(logic [SAMPLE_WIDTH-1:0] s);
        send_item(REQ_FILTER, pack_item(s, '0, '0, '0, '0));
    endtask

    task automatic send_stage(logic [IDX_W-1:0] idx, int k, int c);
        send_item(REQ_LOAD_STAGE, pack_item('0, idx, COEF_W'(k), COMP_W'(c), '0));
    endtask

    task automatic send_tap(logic [IDX_W-1:0] idx, logic [LADDER_W-1:0] nu);
        send_item(REQ_LOAD_TAP, pack_item('0, idx, '0, '0, nu));
    endtask

    // stop sending, wait for every owed result, then let a full-order walk finish
    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (sb.filtered_pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] v);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic set_filter(int unsigned order, logic [CFG_DATA_W-1:0] g);
        drain();
        write_reg(CFG_ORDER, CFG_DATA_W'(order));
        write_reg(CFG_GAIN, g);
    endtask

    // random item: mostly samples and well-formed loads, some noise loads,
    // out-of-range indexes and unknown kinds; unused fields carry random bits
    task automatic make_random_item(output t_req req, output logic [IN_TDATA_W-1:0] d);
        int                      pick;
        int                      k;
        logic [SAMPLE_WIDTH-1:0] s;
        logic [IDX_W-1:0]        idx;
        logic [COEF_W-1:0]       refl;
        logic [COMP_W-1:0]       comp;
        logic [LADDER_W-1:0]     nu;
        s    = $urandom;
        idx  = $urandom;
        refl = $urandom;
        comp = $urandom;
        nu   = $urandom;
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            req = REQ_FILTER;
            case ($urandom_range(0, 9))
                0:       s = 16'h7FFF;
                1:       s = 16'h8000;
                2, 3, 4: s = SAMPLE_WIDTH'($urandom_range(0, 4095)) - 16'd2048;
                default: ;
            endcase
        end else if (pick < 70) begin
            // normalized stage: |k| < 1 with its matching complement
            req  = REQ_LOAD_STAGE;
            idx  = $urandom_range(0, MAX_ORDER - 1);
            k    = $urandom_range(0, 64000) - 32000;
            refl = COEF_W'(k);
            comp = COMP_W'(stage_comp(k));
        end else if (pick < 82) begin
            req = REQ_LOAD_TAP;
            idx = $urandom_range(0, MAX_ORDER);
            if ($urandom_range(0, 3) != 0)
                nu = LADDER_W'($urandom_range(0, 16384)) - 16'd8192;
        end else if (pick < 88) begin
            // arbitrary k and c, index may be out of range
            req = REQ_LOAD_STAGE;
        end else if (pick < 94) begin
            req = REQ_LOAD_TAP;
        end else begin
            req = REQ_UNKNOWN;
        end
        d = pack_item(s, idx, refl, comp, nu);
    endtask

    // ------------------------------------------------------------------------
    // output side: random stall bursts until the calm phase
    // ------------------------------------------------------------------------
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!calm && $urandom_range(0, 7) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // monitor and watchdog: results are checked before the same edge's input
    // item is noted, so a fresh sample never matches an older result
    // ------------------------------------------------------------------------
    initial begin : monitor
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            quiet++;
            if (i_rst_n) begin
                if (i_cfg_we) begin
                    sb.write_reg(i_cfg_idx, i_cfg_wdata);
                    quiet = 0;
                end
                if (m_axis_tvalid && m_axis_tready) begin
                    sb.check_result(m_axis_tdata, m_axis_tuser[0]);
                    quiet = 0;
                end
                if (s_axis_tvalid && s_axis_tready) begin
                    sb.note_item(s_axis_tuser, s_axis_tdata);
                    quiet = 0;
                end
            end
        end
        $display("testbench: FAIL");
        $finish;
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int unsigned           phase_order[10] = '{16, 4, 0, 31, 1, 16, 9, 2, 16, 0};
        logic [CFG_DATA_W-1:0] phase_gain[10]  = '{32'd65536, 32'd98304, 32'hFFFF0000,
                                                   32'd16384, 32'h7FFFFFFF, 32'h80000000,
                                                   32'd0, 32'd200000, 32'd0, 32'd65536};
        int unsigned           order;
        logic [CFG_DATA_W-1:0] g;
        t_req                  req;
        logic [IN_TDATA_W-1:0] d;
        int                    k;

        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = CFG_ORDER;
        i_cfg_wdata   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = REQ_FILTER;
        sb = new();
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // every stage and tap gets a normalized value before any sample reads it
        for (int i = 0; i < MAX_ORDER; i++) begin
            k = $urandom_range(0, 48000) - 24000;
            send_stage(IDX_W'(i), k, stage_comp(k));
        end
        for (int i = 0; i <= MAX_ORDER; i++)
            send_tap(IDX_W'(i), LADDER_W'($urandom_range(0, 16384)) - 16'd8192);

        // directed part at reset settings (order 1, unity gain)
        send_sample(16'h7FFF);
        send_sample(16'h8000);
        send_sample(16'h0000);
        send_sample(16'hFFFF);
        // loads past the stores and an unknown kind must change nothing
        send_stage(5'd16, -32768, 32767);
        send_stage(5'd31, 32767, 0);
        send_tap(5'd17, 16'h7FFF);
        send_tap(5'd31, 16'h8000);
        send_item(REQ_UNKNOWN, pack_item('1, '1, '1, '1, '1));
        send_sample(16'd12345);
        // top tap, used only at full order
        send_tap(5'd16, 16'h8000);
        // extreme stage 0 coefficients
        send_stage(5'd0, 32767, 0);
        send_sample(16'h7FFF);
        send_sample(16'h8000);
        send_stage(5'd0, -32768, 32767);
        send_sample(16'h7FFF);
        send_stage(5'd0, -12000, stage_comp(-12000));
        // order zero: ladder on the sample alone
        set_filter(0, 32'd65536);
        send_sample(16'h8000);
        send_sample(16'h7FFF);
        // order above the built maximum, largest gain
        set_filter(31, 32'h7FFFFFFF);
        send_sample(16'h0001);
        send_sample(16'hFFFF);

        // random phases over a spread of settings; the last one runs without idling
        for (int p = 0; p < 10; p++) begin
            order = phase_order[p];
            g     = phase_gain[p];
            if (p == 8) g = $urandom_range(0, 262144) - 131072;
            if (p == 9) order = $urandom_range(0, 31);
            if (p == 9) calm = 1'b1;
            set_filter(order, g);
            repeat (135) begin
                make_random_item(req, d);
                send_item(req, d);
            end
        end

        drain();
        if (sb.errors == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule

>>> filelist.f
src/nllf_pkg.sv
src/nllf_ctrl.sv
src/nllf_datapath.sv
src/normalized_lattice_ladder_filter_unit.sv
src/nllf_checker.sv
dv/testbench.sv
